// File: design/cau_pkg.sv
package cau_pkg;

   // Operand and result word width, Q format integer + fraction bits
   localparam int W  = 32;
   // Product width
   localparam int PW = 2 * W;
   // Signed width that holds any sum of two products
   localparam int SW = 2 * W + 2;
   // Quotient / root bits produced by the iteration chain
   localparam int QW = W + 1;
   // Partial remainder width: divisor shifted left by QW
   localparam int RW = 3 * W + 1;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4,
      OP_MAG = 3'd5
   } op_type;

   localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [W-1:0] word;
      logic         ovf;
   } sat_type;

   // Work item as it travels through the iteration chain
   typedef struct packed {
      op_type         op;
      logic [W-1:0]   res_re;
      logic [W-1:0]   res_im;
      logic           ovf;
      logic           dz;
      logic           neg_re;
      logic           neg_im;
      logic           big_re;
      logic           big_im;
      logic [RW-1:0]  r_re;
      logic [RW-1:0]  r_im;
      logic [QW-1:0]  q_re;
      logic [QW-1:0]  q_im;
      logic [PW-1:0]  d;
   } cau_item_type;

   // Clip a wide signed value to the word range
   function automatic sat_type sat_word(input logic signed [SW-1:0] v);
      sat_type s;
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = $signed({{(SW-W){1'b0}}, WORD_MAX});
      lo = $signed({{(SW-W){1'b1}}, WORD_MIN});
      if (v > hi) begin
         s.word = WORD_MAX;
         s.ovf  = 1'b1;
      end else if (v < lo) begin
         s.word = WORD_MIN;
         s.ovf  = 1'b1;
      end else begin
         s.word = v[W-1:0];
         s.ovf  = 1'b0;
      end
      return s;
   endfunction

endpackage

// File: design/cau_channels.sv
interface cau_req_if import cau_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          op;
   logic signed [W-1:0] x_real;
   logic signed [W-1:0] x_imag;
   logic signed [W-1:0] y_real;
   logic signed [W-1:0] y_imag;

   modport source (output valid, op, x_real, x_imag, y_real, y_imag, input ready);
   modport sink   (input valid, op, x_real, x_imag, y_real, y_imag, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] res_real;
   logic signed [W-1:0] res_imag;
   logic                overflow;
   logic                div_zero;

   modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
   modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

// File: design/complex_arith_unit.sv
// Channel  Dir  Word contents                               Handshake
// req_ch   in   op, x_real, x_imag, y_real, y_imag          valid / ready
// rsp_ch   out  res_real, res_imag, overflow, div_zero      valid / ready
//
// One word in, one word out per cycle while no output word is held; stages:
// input register, four setup stages, 33 quotient/root bit stages, output register.
// The 33 bit stages (one restoring divide or square-root bit each) set the depth.
// Synchronous active-high reset clears only the valid bits.
// A held output word freezes the whole pipe; req_ch.ready drops in that cycle.
module complex_arith_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);

   // whole pipe moves together when the output register is free or drains
   logic         advance;

   logic         chain_valid [QW+1];
   cau_item_type chain_item  [QW+1];

   // products, sums, dividend/radicand setup, quotient range check
   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req       (req_ch),
      .valid_out (chain_valid[0]),
      .item_out  (chain_item[0])
   );

   // quotient / root bits, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_bit
      cau_iter #(
         .BIT (QW - 1 - k)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (chain_valid[k]),
         .item_in   (chain_item[k]),
         .valid_out (chain_valid[k+1]),
         .item_out  (chain_item[k+1])
      );
   end

   // sign fixup, saturation, output register
   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .valid_in (chain_valid[QW]),
      .item_in  (chain_item[QW]),
      .advance  (advance),
      .rsp      (rsp_ch)
   );

   // zero divisor gives a clean zero word
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.div_zero |->
         !rsp_ch.overflow && rsp_ch.res_real == '0 && rsp_ch.res_imag == '0)
      else $error("div_zero word not zero");

   // overflow only with a clipped part
   a_ovf_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.overflow |->
         rsp_ch.res_real == $signed(WORD_MAX) || rsp_ch.res_real == $signed(WORD_MIN) ||
         rsp_ch.res_imag == $signed(WORD_MAX) || rsp_ch.res_imag == $signed(WORD_MIN))
      else $error("overflow without saturated part");

   // stalled output must block the input side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken during output stall");

endmodule

// File: design/cau_front.sv
module cau_front import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   cau_req_if.sink       req,
   output logic          valid_out,
   output cau_item_type  item_out
);

   assign req.ready = advance;

   // stage 1: input word
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic signed [W-1:0] s1_xr_ff, s1_xi_ff, s1_yr_ff, s1_yi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
      if (advance) begin
         s1_op_ff <= op_type'(req.op);
         s1_xr_ff <= req.x_real;
         s1_xi_ff <= req.x_imag;
         s1_yr_ff <= req.y_real;
         s1_yi_ff <= req.y_imag;
      end
   end

   // stage 2: products, plus add / sub / negate finished here
   logic signed [W-1:0]  mb0, mb1;
   logic signed [PW-1:0] p_in [6];
   logic signed [SW-1:0] e_re, e_im;
   sat_type              e_re_sat, e_im_sat;

   always_comb begin
      mb0     = (s1_op_ff == OP_MAG) ? s1_xr_ff : s1_yr_ff;
      mb1     = (s1_op_ff == OP_MAG) ? s1_xi_ff : s1_yi_ff;
      p_in[0] = PW'(s1_xr_ff) * PW'(mb0);
      p_in[1] = PW'(s1_xi_ff) * PW'(mb1);
      p_in[2] = PW'(s1_xi_ff) * PW'(s1_yr_ff);
      p_in[3] = PW'(s1_xr_ff) * PW'(s1_yi_ff);
      p_in[4] = PW'(s1_yr_ff) * PW'(s1_yr_ff);
      p_in[5] = PW'(s1_yi_ff) * PW'(s1_yi_ff);
      case (s1_op_ff)
         OP_ADD: begin
            e_re = SW'(s1_xr_ff) + SW'(s1_yr_ff);
            e_im = SW'(s1_xi_ff) + SW'(s1_yi_ff);
         end
         OP_SUB: begin
            e_re = SW'(s1_xr_ff) - SW'(s1_yr_ff);
            e_im = SW'(s1_xi_ff) - SW'(s1_yi_ff);
         end
         OP_NEG: begin
            e_re = -SW'(s1_xr_ff);
            e_im = -SW'(s1_xi_ff);
         end
         default: begin
            e_re = '0;
            e_im = '0;
         end
      endcase
      e_re_sat = sat_word(e_re);
      e_im_sat = sat_word(e_im);
   end

   logic                 s2_valid_ff;
   op_type               s2_op_ff;
   logic signed [PW-1:0] s2_p_ff [6];
   logic [W-1:0]         s2_res_re_ff, s2_res_im_ff;
   logic                 s2_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_op_ff     <= s1_op_ff;
         s2_p_ff      <= p_in;
         s2_res_re_ff <= e_re_sat.word;
         s2_res_im_ff <= e_im_sat.word;
         s2_ovf_ff    <= e_re_sat.ovf | e_im_sat.ovf;
      end
   end

   // stage 3: sums of products
   logic signed [SW-1:0] sum_re_in, sum_im_in;
   logic [PW-1:0]        d_in;

   always_comb begin
      if (s2_op_ff == OP_MUL) begin
         sum_re_in = SW'(s2_p_ff[0]) - SW'(s2_p_ff[1]);
         sum_im_in = SW'(s2_p_ff[2]) + SW'(s2_p_ff[3]);
      end else begin
         sum_re_in = SW'(s2_p_ff[0]) + SW'(s2_p_ff[1]);
         sum_im_in = SW'(s2_p_ff[2]) - SW'(s2_p_ff[3]);
      end
      d_in = $unsigned(s2_p_ff[4]) + $unsigned(s2_p_ff[5]);
   end

   logic                 s3_valid_ff;
   op_type               s3_op_ff;
   logic signed [SW-1:0] s3_sum_re_ff, s3_sum_im_ff;
   logic [PW-1:0]        s3_d_ff;
   logic [W-1:0]         s3_res_re_ff, s3_res_im_ff;
   logic                 s3_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_op_ff     <= s2_op_ff;
         s3_sum_re_ff <= sum_re_in;
         s3_sum_im_ff <= sum_im_in;
         s3_d_ff      <= d_in;
         s3_res_re_ff <= s2_res_re_ff;
         s3_res_im_ff <= s2_res_im_ff;
         s3_ovf_ff    <= s2_ovf_ff;
      end
   end

   // stage 4: multiply rescale, dividend / radicand setup
   cau_item_type         s4_in;
   logic signed [SW-1:0] sh_re, sh_im, mag_re, mag_im;
   sat_type              m_re_sat, m_im_sat;

   always_comb begin
      sh_re    = s3_sum_re_ff >>> FRAC_BITS;
      sh_im    = s3_sum_im_ff >>> FRAC_BITS;
      m_re_sat = sat_word(sh_re);
      m_im_sat = sat_word(sh_im);
      mag_re   = s3_sum_re_ff[SW-1] ? -s3_sum_re_ff : s3_sum_re_ff;
      mag_im   = s3_sum_im_ff[SW-1] ? -s3_sum_im_ff : s3_sum_im_ff;
      s4_in        = '0;
      s4_in.op     = s3_op_ff;
      s4_in.res_re = s3_res_re_ff;
      s4_in.res_im = s3_res_im_ff;
      s4_in.ovf    = s3_ovf_ff;
      s4_in.d      = s3_d_ff;
      case (s3_op_ff)
         OP_MUL: begin
            s4_in.res_re = m_re_sat.word;
            s4_in.res_im = m_im_sat.word;
            s4_in.ovf    = m_re_sat.ovf | m_im_sat.ovf;
         end
         OP_DIV: begin
            s4_in.dz     = (s3_d_ff == '0);
            s4_in.neg_re = s3_sum_re_ff[SW-1];
            s4_in.neg_im = s3_sum_im_ff[SW-1];
            s4_in.r_re   = RW'(mag_re[PW-1:0]) << FRAC_BITS;
            s4_in.r_im   = RW'(mag_im[PW-1:0]) << FRAC_BITS;
         end
         OP_MAG: begin
            s4_in.r_re = RW'(s3_sum_re_ff[PW-1:0]);
         end
         default: ;
      endcase
   end

   logic         s4_valid_ff;
   cau_item_type s4_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_item_ff <= s4_in;
      end
   end

   // stage 5: quotient range check, quotient must fit in QW bits
   cau_item_type  s5_in;
   logic [RW-1:0] d_top;

   always_comb begin
      d_top  = RW'(s4_item_ff.d) << QW;
      s5_in  = s4_item_ff;
      if (s4_item_ff.op == OP_DIV) begin
         s5_in.big_re = (s4_item_ff.r_re >= d_top);
         s5_in.big_im = (s4_item_ff.r_im >= d_top);
      end
   end

   logic         s5_valid_ff;
   cau_item_type s5_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_item_ff <= s5_in;
      end
   end

   assign valid_out = s5_valid_ff;
   assign item_out  = s5_item_ff;

endmodule

// File: design/cau_iter.sv
module cau_iter import cau_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          valid_in,
   input  cau_item_type  item_in,
   output logic          valid_out,
   output cau_item_type  item_out
);

   // one quotient bit per lane, or one root bit on the real lane
   cau_item_type  item_in_next;
   logic [RW-1:0] t_re, t_im;

   always_comb begin
      item_in_next = item_in;
      t_im = RW'(item_in.d) << BIT;
      if (item_in.op == OP_MAG) begin
         t_re = (RW'(item_in.q_re) << (BIT + 1)) + (RW'(1) << (2 * BIT));
      end else begin
         t_re = t_im;
      end
      if ((item_in.op == OP_DIV || item_in.op == OP_MAG) && item_in.r_re >= t_re) begin
         item_in_next.r_re      = item_in.r_re - t_re;
         item_in_next.q_re[BIT] = 1'b1;
      end
      if (item_in.op == OP_DIV && item_in.r_im >= t_im) begin
         item_in_next.r_im      = item_in.r_im - t_im;
         item_in_next.q_im[BIT] = 1'b1;
      end
   end

   logic         valid_ff;
   cau_item_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         item_ff <= item_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

// File: design/cau_back.sv
module cau_back import cau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  cau_item_type  item_in,
   output logic          advance,
   cau_rsp_if.source     rsp
);

   sat_type              f_re, f_im;
   logic                 dz;
   logic signed [SW-1:0] v_re, v_im;

   always_comb begin
      v_re = item_in.neg_re ? -SW'(item_in.q_re) : SW'(item_in.q_re);
      v_im = item_in.neg_im ? -SW'(item_in.q_im) : SW'(item_in.q_im);
      dz   = 1'b0;
      f_re = '0;
      f_im = '0;
      case (item_in.op) inside
         OP_ADD, OP_SUB, OP_NEG, OP_MUL: begin
            f_re.word = item_in.res_re;
            f_re.ovf  = item_in.ovf;
            f_im.word = item_in.res_im;
         end
         OP_DIV: begin
            if (item_in.dz) begin
               dz = 1'b1;
            end else begin
               if (item_in.big_re) begin
                  f_re.word = item_in.neg_re ? WORD_MIN : WORD_MAX;
                  f_re.ovf  = 1'b1;
               end else begin
                  f_re = sat_word(v_re);
               end
               if (item_in.big_im) begin
                  f_im.word = item_in.neg_im ? WORD_MIN : WORD_MAX;
                  f_im.ovf  = 1'b1;
               end else begin
                  f_im = sat_word(v_im);
               end
            end
         end
         OP_MAG: begin
            f_re = sat_word(SW'(item_in.q_re));
         end
         default: ;
      endcase
   end

   logic         out_valid_ff;
   logic [W-1:0] out_re_ff, out_im_ff;
   logic         out_ovf_ff, out_dz_ff;

   assign advance = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_in;
      end
      if (advance) begin
         out_re_ff  <= f_re.word;
         out_im_ff  <= f_im.word;
         out_ovf_ff <= f_re.ovf | f_im.ovf;
         out_dz_ff  <= dz;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.res_real = $signed(out_re_ff);
   assign rsp.res_imag = $signed(out_im_ff);
   assign rsp.overflow = out_ovf_ff;
   assign rsp.div_zero = out_dz_ff;

endmodule
